>>> design/ouks_pkg.sv
// ----------------------------------------------------------------------------
// ouks_pkg
// Shared types, sizes and codes for the ordered unique key set.
// ----------------------------------------------------------------------------
package ouks_pkg;

    // Store sizing
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;

    // Fixed field widths of the request and result
    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int WHERE_W = 6;
    localparam int TOTAL_W = 7;
    localparam int STS_W   = 2;

    // Derived widths
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int KEXT_W = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROP_AT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROP_KEY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_MISSING = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [WHERE_W-1:0] where_index;
        logic [TOTAL_W-1:0] entry_total;
        logic [STS_W-1:0]   status;
    } t_out_item;

    // Controller to store: one write port, one read port
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [KEY_BITS-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;

    // Count or index to the position field width (masked)
    function automatic logic [WHERE_W-1:0] to_where(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] tmp;
        tmp = WIDE_W'(v);
        return tmp[WHERE_W-1:0];
    endfunction

    // Count to the total field width (masked)
    function automatic logic [TOTAL_W-1:0] to_total(input logic [CNT_W-1:0] v);
        logic [WIDE_W-1:0] tmp;
        tmp = WIDE_W'(v);
        return tmp[TOTAL_W-1:0];
    endfunction

endpackage

>>> design/ouks_store.sv
// ----------------------------------------------------------------------------
// ouks_store
// Key store: one synchronous write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ouks_store (
    input  logic                          i_clk,
    input  ouks_pkg::t_mem_req            i_req,
    output logic [ouks_pkg::KEY_BITS-1:0] o_rd_data
);
    import ouks_pkg::*;

    logic [KEY_BITS-1:0] r_mem [CAPACITY];
    logic [KEY_BITS-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ouks_ctrl.sv
// ----------------------------------------------------------------------------
// ouks_ctrl
// Sequencer: scans the store for a key, shifts entries down on removal and
// commits the entry count when the result is handed over.
// ----------------------------------------------------------------------------
module ouks_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ouks_pkg::t_in_item            i_in_data,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ouks_pkg::t_out_item           o_res,
    output ouks_pkg::t_mem_req            o_mem_req,
    input  logic [ouks_pkg::KEY_BITS-1:0] i_rd_data
);
    import ouks_pkg::*;

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_lim, n_lim;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_pend, n_pend;
    logic [CNT_W-1:0]    r_pend_idx, n_pend_idx;
    logic                r_found, n_found;
    logic [CNT_W-1:0]    r_where, n_where;
    logic [STS_W-1:0]    r_status, n_status;

    logic                accept;
    logic                pos_ok;
    logic [WIDE_W-1:0]   pos_wide;
    logic [KEXT_W-1:0]   key_ext;
    logic                issue_more;
    logic                scan_hit;
    logic                scan_miss;
    logic                shift_end;
    logic [CNT_W-1:0]    prev_idx;
    logic [CNT_W-1:0]    count_after;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign pos_wide   = WIDE_W'(i_in_data.position);
    assign pos_ok     = pos_wide < WIDE_W'(r_count);
    assign key_ext    = KEXT_W'(i_in_data.key);
    assign issue_more = r_issue < r_lim;
    assign scan_hit   = r_pend && (i_rd_data == r_key);
    assign scan_miss  = !issue_more && !scan_hit;
    assign shift_end  = !issue_more && !r_pend;
    assign prev_idx   = r_pend_idx - 1'b1;

    // Entry count once this request is committed
    always_comb begin
        count_after = r_count;
        case (r_kind) inside
            KIND_PUSH: begin
                if (r_status == STS_OK && !r_found) begin
                    count_after = r_count + 1'b1;
                end
            end
            KIND_DROP_AT, KIND_DROP_KEY: begin
                if (r_status == STS_OK) begin
                    count_after = r_count - 1'b1;
                end
            end
            KIND_CLEAR: count_after = '0;
            default:    count_after = r_count;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.kind) inside
                        KIND_PUSH, KIND_FIND, KIND_DROP_KEY: n_state = S_SCAN;
                        KIND_DROP_AT: n_state = pos_ok ? S_SHIFT : S_DONE;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_kind == KIND_DROP_KEY) ? S_SHIFT : S_DONE;
                end else if (scan_miss) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (shift_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory requests and outputs
    always_comb begin
        n_kind     = r_kind;
        n_key      = r_key;
        n_count    = r_count;
        n_lim      = r_lim;
        n_issue    = r_issue;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_found    = r_found;
        n_where    = r_where;
        n_status   = r_status;

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = prev_idx[ADDR_W-1:0];
        o_mem_req.wdata = i_rd_data;
        o_mem_req.raddr = r_issue[ADDR_W-1:0];

        o_in_ready        = (r_state == S_IDLE);
        o_res_valid       = (r_state == S_DONE);
        o_res.found       = r_found;
        o_res.where_index = to_where(r_where);
        o_res.entry_total = to_total(count_after);
        o_res.status      = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_in_data.kind;
                    n_key    = key_ext[KEY_BITS-1:0];
                    n_found  = 1'b0;
                    n_where  = '0;
                    n_status = STS_OK;
                    n_issue  = '0;
                    n_lim    = r_count;
                    if (i_in_data.kind == KIND_DROP_AT) begin
                        if (pos_ok) begin
                            n_where = CNT_W'(pos_wide);
                            n_issue = CNT_W'(pos_wide + 1'b1);
                        end else begin
                            n_status = STS_RANGE;
                        end
                    end
                end
            end
            S_SCAN: begin
                // One read issued per cycle, compared in the next cycle
                if (issue_more) begin
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                end
                if (scan_hit) begin
                    n_found = 1'b1;
                    n_where = r_pend_idx;
                    n_pend  = 1'b0;
                    n_issue = r_pend_idx + 1'b1;
                end else if (scan_miss) begin
                    if (r_kind == KIND_PUSH) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = STS_FULL;
                        end else begin
                            n_where = r_count;
                        end
                    end else begin
                        n_status = STS_MISSING;
                    end
                end
            end
            S_SHIFT: begin
                // Read entry i, write it back at i-1 in the next cycle
                if (issue_more) begin
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                end
                if (r_pend) begin
                    o_mem_req.we = 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_count = count_after;
                    if (r_kind == KIND_PUSH && r_status == STS_OK && !r_found) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_count[ADDR_W-1:0];
                        o_mem_req.wdata = r_key;
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_lim      <= n_lim;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_where    <= n_where;
        r_status   <= n_status;
    end

endmodule

>>> design/ordered_unique_key_set.sv
// ----------------------------------------------------------------------------
// ordered_unique_key_set
// Insertion-ordered set of unique keys in a fixed store with compaction.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with i_in_data (kind, key,
//   position); each request gives exactly one result on o_out_valid /
//   i_out_ready with o_out_data (found, where_index, entry_total, status).
//   Requests are handled one at a time.
// Flow, with n the entry count and p the position or hit index:
//   push, find and remove-key scan the store from index 0 up to a hit at p
//   or, on a miss, to entry n - 1; remove-key then shifts the tail above p
//   down by one; remove-at shifts the tail above p down the same way;
//   out-of-range remove-at, clear and unused kinds go straight to the result.
//   Scan and shift make one store read per cycle; the controller is ready
//   for the next request in the cycle after it hands a result over.
// Reset clears the entry count and all handshake state; store contents are
//   not cleared and no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and one
//   more request is taken and worked; it then holds until the register frees.
// ----------------------------------------------------------------------------
module ordered_unique_key_set (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ouks_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ouks_pkg::t_out_item  o_out_data
);
    import ouks_pkg::*;

    t_mem_req            mem_req;
    logic [KEY_BITS-1:0] rd_data;
    logic                res_valid;
    logic                res_ready;
    t_out_item           res;

    logic                r_out_valid;
    t_out_item           r_out_data;

    ouks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    ouks_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Output register: free when empty or being taken
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/ouks_checker.sv
// ----------------------------------------------------------------------------
// ouks_port_checker
// Port-level checks on the result channel of the ordered unique key set.
// ----------------------------------------------------------------------------
module ouks_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ouks_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ouks_pkg::t_out_item o_out_data
);
    import ouks_pkg::*;

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Total never exceeds the capacity
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WIDE_W'(o_out_data.entry_total) <= WIDE_W'(CAPACITY)))
        else $error("entry total above capacity");

    // Full is reported only with a full store
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STS_FULL) |->
        (o_out_data.entry_total == to_total(CNT_W'(CAPACITY))) && !o_out_data.found)
        else $error("full status with room left");

    // A hit always comes with ok status
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> (o_out_data.status == STS_OK))
        else $error("found with error status");

    // Failed requests report position zero
    a_where: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STS_OK) |-> (o_out_data.where_index == '0))
        else $error("error result with nonzero position");

endmodule

bind ordered_unique_key_set ouks_port_checker u_ouks_checker (.*);
